// ===== hdl/pgr_pkg.sv =====
// Promotion gain ranker: shared constants, types and constant tables.
// No dependencies; used by pgr_ctrl, pgr_dp and the top level.
`timescale 1ns / 1ps

package pgr_pkg;

  localparam int HOTNESS_BINS = 32;
  localparam int NUM_PAIRS    = 6;
  localparam int PATH_SLOTS   = HOTNESS_BINS * NUM_PAIRS;
  localparam int BIN_W        = $clog2(HOTNESS_BINS);
  localparam int PAIR_W       = 3;
  localparam int TIER_W       = 2;
  localparam int ADDR_W       = $clog2(PATH_SLOTS);
  localparam int CNT_W        = $clog2(PATH_SLOTS + 1);
  localparam int ENTRY_W      = BIN_W + 2 * TIER_W;

  localparam int SAMPLE_W = 32;
  localparam int TOTAL_W  = SAMPLE_W + 2;
  localparam int REM_W    = TOTAL_W + 1;
  localparam int QUOT_W   = 17;
  localparam int DIV_STEPS = QUOT_W;
  localparam int ALPHA_W  = 21;
  localparam int WEIGHT_W = 19;
  localparam int IDX_W    = 8;
  localparam int OUT_BIN_W = 5;
  localparam int OUT_CNT_W = 8;
  localparam int STEP_W   = 5;

  localparam int K_W  = 16;
  localparam int CX_W = 26;
  localparam int CT_W = CX_W + WEIGHT_W - 16;
  localparam int BEN_W = HOTNESS_BINS - 1 + K_W;
  localparam int G_W  = (BEN_W > CT_W) ? BEN_W : CT_W;
  localparam int S_W  = G_W + 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 21;
  localparam logic [CFG_IDX_W-1:0] CFG_DYN_EN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = 2'd1;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 19'd65536;
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 19'd262144;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_SUM,
    OP_W_ONE,
    OP_W_KEEP,
    OP_DIV,
    OP_W_SET,
    OP_COST,
    OP_HEAD,
    OP_SEL,
    OP_UPD,
    OP_RD,
    OP_OUT_RECOMP,
    OP_OUT_READ
  } dp_op_e;

  typedef struct packed {
    dp_op_e            op;
    logic [PAIR_W-1:0] pair;
    logic              first;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic dyn_en;
    logic total_zero;
    logic any_active;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic              act;
    logic [G_W-1:0]    gain;
    logic [BIN_W-1:0]  bin;
    logic [PAIR_W-1:0] pair;
  } cand_t;

  // 200 * latency gap of each (src, dst) pair
  function automatic logic [K_W-1:0] pgr_k(input logic [PAIR_W-1:0] p);
    logic [K_W-1:0] k;
    unique case (p)
      3'd0:    k = 16'd10000;
      3'd1:    k = 16'd44000;
      3'd2:    k = 16'd34000;
      3'd3:    k = 16'd54000;
      3'd4:    k = 16'd44000;
      3'd5:    k = 16'd10000;
      default: k = '0;
    endcase
    return k;
  endfunction

  // move cost * 20000
  function automatic logic [CX_W-1:0] pgr_cx(input logic [PAIR_W-1:0] p);
    logic [CX_W-1:0] c;
    unique case (p)
      3'd0:    c = 26'd23240000;
      3'd1:    c = 26'd38680000;
      3'd2:    c = 26'd36040000;
      3'd3:    c = 26'd60100000;
      3'd4:    c = 26'd54720000;
      3'd5:    c = 26'd53720000;
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic [TIER_W-1:0] pgr_src(input logic [PAIR_W-1:0] p);
    logic [TIER_W-1:0] s;
    unique case (p)
      3'd0:          s = 2'd1;
      3'd1, 3'd2:    s = 2'd2;
      3'd3, 3'd4, 3'd5: s = 2'd3;
      default:       s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [TIER_W-1:0] pgr_dst(input logic [PAIR_W-1:0] p);
    logic [TIER_W-1:0] d;
    unique case (p)
      3'd0, 3'd1, 3'd3: d = 2'd0;
      3'd2, 3'd4:       d = 2'd1;
      3'd5:             d = 2'd2;
      default:          d = '0;
    endcase
    return d;
  endfunction

  // higher gain wins; on a tie the higher bin wins, then the higher pair
  function automatic logic pgr_better(input cand_t a, input cand_t b);
    logic r;
    if (!a.act) r = 1'b0;
    else if (!b.act) r = 1'b1;
    else if (a.gain != b.gain) r = (a.gain > b.gain);
    else if (a.bin != b.bin) r = (a.bin > b.bin);
    else r = (a.pair > b.pair);
    return r;
  endfunction

endpackage

// ===== hdl/pgr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module pgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/pgr_ctrl.sv =====
// Promotion gain ranker controller: sequences weight update, path merge and reads.
// Depends on pgr_pkg.
`timescale 1ns / 1ps

module pgr_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  pgr_pkg::status_t status_i,
  output pgr_pkg::cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_BRANCH, ST_SUM, ST_WSEL, ST_DIV, ST_WSET, ST_COST, ST_HEAD,
    ST_SEL, ST_UPD, ST_RD, ST_DONE
  } state_e;

  state_e                      state_q;
  logic [pgr_pkg::STEP_W-1:0]  cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_BRANCH;
        end
        ST_BRANCH: state_q <= status_i.mode ? ST_RD : ST_SUM;
        ST_SUM:    state_q <= ST_WSEL;
        ST_WSEL: begin
          cnt_q <= '0;
          if (status_i.dyn_en && !status_i.total_zero) state_q <= ST_DIV;
          else state_q <= ST_COST;
        end
        ST_DIV: begin
          if (cnt_q == pgr_pkg::STEP_W'(pgr_pkg::DIV_STEPS - 1)) begin
            state_q <= ST_WSET;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_WSET: begin
          cnt_q   <= '0;
          state_q <= ST_COST;
        end
        ST_COST: begin
          if (cnt_q == pgr_pkg::STEP_W'(pgr_pkg::NUM_PAIRS - 1)) begin
            cnt_q   <= '0;
            state_q <= ST_HEAD;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_HEAD: begin
          if (cnt_q == pgr_pkg::STEP_W'(pgr_pkg::NUM_PAIRS - 1)) begin
            state_q <= ST_SEL;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_SEL:  state_q <= status_i.any_active ? ST_UPD : ST_DONE;
        ST_UPD:  state_q <= ST_SEL;
        ST_RD:   state_q <= ST_DONE;
        ST_DONE: begin
          if (status_i.out_free) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o       = '0;
    cmd_o.op    = pgr_pkg::OP_NONE;
    cmd_o.pair  = cnt_q[pgr_pkg::PAIR_W-1:0];
    cmd_o.first = (cnt_q == '0);
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) cmd_o.op = pgr_pkg::OP_CAPTURE;
      ST_SUM:    cmd_o.op = pgr_pkg::OP_SUM;
      ST_WSEL: begin
        if (!status_i.dyn_en) cmd_o.op = pgr_pkg::OP_W_ONE;
        else if (status_i.total_zero) cmd_o.op = pgr_pkg::OP_W_KEEP;
      end
      ST_DIV:    cmd_o.op = pgr_pkg::OP_DIV;
      ST_WSET:   cmd_o.op = pgr_pkg::OP_W_SET;
      ST_COST:   cmd_o.op = pgr_pkg::OP_COST;
      ST_HEAD:   cmd_o.op = pgr_pkg::OP_HEAD;
      ST_SEL:    cmd_o.op = pgr_pkg::OP_SEL;
      ST_UPD:    cmd_o.op = pgr_pkg::OP_UPD;
      ST_RD:     cmd_o.op = pgr_pkg::OP_RD;
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.op = status_i.mode ? pgr_pkg::OP_OUT_READ : pgr_pkg::OP_OUT_RECOMP;
        end
      end
      default:   cmd_o.op = pgr_pkg::OP_NONE;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

// ===== hdl/pgr_dp.sv =====
// Promotion gain ranker datapath: config, divider, cost terms, merge heads, ranking RAM.
// Depends on pgr_pkg and pgr_ram.
`timescale 1ns / 1ps

module pgr_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pgr_pkg::cmd_t                     cmd_i,
  output pgr_pkg::status_t                  status_o,
  input  logic                              cfg_valid_i,
  input  logic [pgr_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pgr_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              mode_i,
  input  logic [pgr_pkg::SAMPLE_W-1:0]      samples_tier0_i,
  input  logic [pgr_pkg::SAMPLE_W-1:0]      samples_tier1_i,
  input  logic [pgr_pkg::SAMPLE_W-1:0]      samples_tier2_i,
  input  logic [pgr_pkg::SAMPLE_W-1:0]      samples_tier3_i,
  input  logic [pgr_pkg::IDX_W-1:0]         rank_index_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [pgr_pkg::OUT_BIN_W-1:0]     entry_bin_o,
  output logic [pgr_pkg::TIER_W-1:0]        entry_source_o,
  output logic [pgr_pkg::TIER_W-1:0]        entry_destination_o,
  output logic                              entry_valid_o,
  output logic [pgr_pkg::OUT_CNT_W-1:0]     positive_count_o,
  output logic [pgr_pkg::WEIGHT_W-1:0]      weight_now_o
);

  localparam int NP = pgr_pkg::NUM_PAIRS;

  logic                              dyn_q;
  logic [pgr_pkg::ALPHA_W-1:0]       alpha_q;
  logic                              mode_q;
  logic [pgr_pkg::SAMPLE_W-1:0]      t0_q, t1_q, t2_q, t3_q;
  logic [pgr_pkg::IDX_W-1:0]         idx_q;
  logic [pgr_pkg::TOTAL_W-1:0]       total_q;
  logic [pgr_pkg::REM_W-1:0]         rem_q;
  logic [pgr_pkg::QUOT_W-1:0]        quot_q;
  logic [pgr_pkg::WEIGHT_W-1:0]      weight_q;
  logic [pgr_pkg::CT_W-1:0]          ct_q   [NP];
  logic [pgr_pkg::G_W-1:0]           gain_q [NP];
  logic [pgr_pkg::BIN_W-1:0]         bin_q  [NP];
  logic [NP-1:0]                     act_q;
  logic [pgr_pkg::PAIR_W-1:0]        win_q;
  logic [pgr_pkg::CNT_W-1:0]         count_q;

  logic                              out_valid_q;
  logic [pgr_pkg::OUT_BIN_W-1:0]     o_bin_q;
  logic [pgr_pkg::TIER_W-1:0]        o_src_q, o_dst_q;
  logic                              o_ok_q;
  logic [pgr_pkg::OUT_CNT_W-1:0]     o_cnt_q;
  logic [pgr_pkg::WEIGHT_W-1:0]      o_w_q;

  // divider step
  logic [pgr_pkg::REM_W-1:0]         trial;
  logic                              ge;
  always_comb begin
    trial = cmd_i.first ? rem_q : {rem_q[pgr_pkg::REM_W-2:0], 1'b0};
    ge    = (trial >= pgr_pkg::REM_W'(total_q));
  end

  // weight select
  logic [pgr_pkg::WEIGHT_W-1:0]      floor_w, share_w, max_w;
  always_comb begin
    floor_w = pgr_pkg::WEIGHT_W'(alpha_q >> 2);
    share_w = pgr_pkg::WEIGHT_W'(quot_q);
    max_w   = (share_w > floor_w) ? share_w : floor_w;
    if (max_w > pgr_pkg::WEIGHT_MAX) max_w = pgr_pkg::WEIGHT_MAX;
  end

  // cost term of one pair
  logic [pgr_pkg::CX_W+pgr_pkg::WEIGHT_W-1:0] prod;
  assign prod = pgr_pkg::pgr_cx(cmd_i.pair) * weight_q;

  // gain of one pair at one bin
  logic [pgr_pkg::PAIR_W-1:0]        hp;
  logic [pgr_pkg::BIN_W-1:0]         hb;
  logic [pgr_pkg::S_W-1:0]           k_ext, ben;
  logic signed [pgr_pkg::S_W-1:0]    g;
  logic                              g_pos;
  always_comb begin
    hp = (cmd_i.op == pgr_pkg::OP_UPD) ? win_q : cmd_i.pair;
    hb = (cmd_i.op == pgr_pkg::OP_UPD) ? (bin_q[win_q] - 1'b1)
                                       : pgr_pkg::BIN_W'(pgr_pkg::HOTNESS_BINS - 1);
    k_ext = pgr_pkg::S_W'(pgr_pkg::pgr_k(hp));
    ben   = (k_ext << hb) - k_ext;
    g     = $signed(ben) - $signed(pgr_pkg::S_W'(ct_q[hp]));
    g_pos = !g[pgr_pkg::S_W-1] && (g != '0);
  end

  // six-way head selection
  pgr_pkg::cand_t c [NP];
  pgr_pkg::cand_t w01, w23, w45, w03, wall;
  always_comb begin
    for (int p = 0; p < NP; p++) begin
      c[p].act  = act_q[p];
      c[p].gain = gain_q[p];
      c[p].bin  = bin_q[p];
      c[p].pair = pgr_pkg::PAIR_W'(p);
    end
    w01  = pgr_pkg::pgr_better(c[0], c[1]) ? c[0] : c[1];
    w23  = pgr_pkg::pgr_better(c[2], c[3]) ? c[2] : c[3];
    w45  = pgr_pkg::pgr_better(c[4], c[5]) ? c[4] : c[5];
    w03  = pgr_pkg::pgr_better(w01, w23) ? w01 : w23;
    wall = pgr_pkg::pgr_better(w03, w45) ? w03 : w45;
  end

  // ranking store
  logic                              ram_we, ram_re;
  logic [pgr_pkg::ENTRY_W-1:0]       ram_wdata, ram_rdata;
  logic                              rd_ok;

  assign ram_we    = (cmd_i.op == pgr_pkg::OP_UPD);
  assign ram_re    = (cmd_i.op == pgr_pkg::OP_RD);
  assign ram_wdata = {bin_q[win_q], pgr_pkg::pgr_src(win_q), pgr_pkg::pgr_dst(win_q)};
  assign rd_ok     = ({1'b0, idx_q} < 9'(count_q));

  pgr_ram #(
    .WIDTH (pgr_pkg::ENTRY_W),
    .DEPTH (pgr_pkg::PATH_SLOTS)
  ) u_rank_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[pgr_pkg::ADDR_W-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q[pgr_pkg::ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dyn_q       <= 1'b1;
      alpha_q     <= '0;
      weight_q    <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == pgr_pkg::CFG_DYN_EN) dyn_q <= cfg_data_i[0];
        else if (cfg_index_i == pgr_pkg::CFG_ALPHA) alpha_q <= cfg_data_i;
      end
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (cmd_i.op)
        pgr_pkg::OP_SUM:    count_q <= '0;
        pgr_pkg::OP_W_ONE:  weight_q <= pgr_pkg::WEIGHT_ONE;
        pgr_pkg::OP_W_KEEP: if (weight_q == '0) weight_q <= pgr_pkg::WEIGHT_ONE;
        pgr_pkg::OP_W_SET:  weight_q <= max_w;
        pgr_pkg::OP_UPD:    count_q <= count_q + 1'b1;
        pgr_pkg::OP_OUT_RECOMP, pgr_pkg::OP_OUT_READ: out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      pgr_pkg::OP_CAPTURE: begin
        mode_q <= mode_i;
        t0_q   <= samples_tier0_i;
        t1_q   <= samples_tier1_i;
        t2_q   <= samples_tier2_i;
        t3_q   <= samples_tier3_i;
        idx_q  <= rank_index_i;
      end
      pgr_pkg::OP_SUM: begin
        total_q <= (pgr_pkg::TOTAL_W'(t0_q) + pgr_pkg::TOTAL_W'(t1_q))
                 + (pgr_pkg::TOTAL_W'(t2_q) + pgr_pkg::TOTAL_W'(t3_q));
        rem_q   <= pgr_pkg::REM_W'(t0_q);
        quot_q  <= '0;
      end
      pgr_pkg::OP_DIV: begin
        rem_q  <= ge ? (trial - pgr_pkg::REM_W'(total_q)) : trial;
        quot_q <= {quot_q[pgr_pkg::QUOT_W-2:0], ge};
      end
      pgr_pkg::OP_COST: ct_q[cmd_i.pair] <= prod[pgr_pkg::CX_W+pgr_pkg::WEIGHT_W-1:16];
      pgr_pkg::OP_HEAD: begin
        bin_q[cmd_i.pair]  <= pgr_pkg::BIN_W'(pgr_pkg::HOTNESS_BINS - 1);
        gain_q[cmd_i.pair] <= g[pgr_pkg::G_W-1:0];
        act_q[cmd_i.pair]  <= g_pos;
      end
      pgr_pkg::OP_SEL: win_q <= wall.pair;
      pgr_pkg::OP_UPD: begin
        if (bin_q[win_q] == '0) begin
          act_q[win_q] <= 1'b0;
        end else begin
          bin_q[win_q]  <= hb;
          gain_q[win_q] <= g[pgr_pkg::G_W-1:0];
          act_q[win_q]  <= g_pos;
        end
      end
      pgr_pkg::OP_OUT_RECOMP: begin
        o_bin_q <= '0;
        o_src_q <= '0;
        o_dst_q <= '0;
        o_ok_q  <= 1'b0;
        o_cnt_q <= pgr_pkg::OUT_CNT_W'(count_q);
        o_w_q   <= weight_q;
      end
      pgr_pkg::OP_OUT_READ: begin
        o_bin_q <= rd_ok ? pgr_pkg::OUT_BIN_W'(ram_rdata[pgr_pkg::ENTRY_W-1:2*pgr_pkg::TIER_W])
                         : '0;
        o_src_q <= rd_ok ? ram_rdata[2*pgr_pkg::TIER_W-1:pgr_pkg::TIER_W] : '0;
        o_dst_q <= rd_ok ? ram_rdata[pgr_pkg::TIER_W-1:0] : '0;
        o_ok_q  <= rd_ok;
        o_cnt_q <= pgr_pkg::OUT_CNT_W'(count_q);
        o_w_q   <= weight_q;
      end
      default: ;
    endcase
  end

  assign status_o.mode       = mode_q;
  assign status_o.dyn_en     = dyn_q;
  assign status_o.total_zero = (total_q == '0);
  assign status_o.any_active = |act_q;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o         = out_valid_q;
  assign entry_bin_o         = o_bin_q;
  assign entry_source_o      = o_src_q;
  assign entry_destination_o = o_dst_q;
  assign entry_valid_o       = o_ok_q;
  assign positive_count_o    = o_cnt_q;
  assign weight_now_o        = o_w_q;

endmodule

// ===== hdl/promotion_gain_ranker.sv =====
// Promotion gain ranker top level: controller plus datapath.
// Depends on pgr_pkg, pgr_ctrl, pgr_dp (and pgr_ram through pgr_dp).
//
//   channel | signals                               | direction
//   in      | in_valid_i/in_ready_o, request fields | into block
//   out     | out_valid_o/out_ready_i, result       | out of block
//   cfg     | cfg_valid_i/cfg_ready_o, index, data  | into block
//
// A read request passes branch, read and done states before its result is valid.
// A recompute request sums the samples, runs a restoring divider, forms the cost
// term and merge head of each pair, then runs a six-way merge of the per-pair bin
// lists that ranks the positive-gain paths (at most 186), each by a select, then
// a write; the divider is skipped with dynamic weight off or no samples.
// No request is taken while one is in work; a finished result waits in the output
// register. Reset clears weight, count and alpha and sets dyn_q; RAM is not cleared.
`timescale 1ns / 1ps

module promotion_gain_ranker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              mode_i,
  input  logic [pgr_pkg::SAMPLE_W-1:0]      samples_tier0_i,
  input  logic [pgr_pkg::SAMPLE_W-1:0]      samples_tier1_i,
  input  logic [pgr_pkg::SAMPLE_W-1:0]      samples_tier2_i,
  input  logic [pgr_pkg::SAMPLE_W-1:0]      samples_tier3_i,
  input  logic [pgr_pkg::IDX_W-1:0]         rank_index_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [pgr_pkg::OUT_BIN_W-1:0]     entry_bin_o,
  output logic [pgr_pkg::TIER_W-1:0]        entry_source_o,
  output logic [pgr_pkg::TIER_W-1:0]        entry_destination_o,
  output logic                              entry_valid_o,
  output logic [pgr_pkg::OUT_CNT_W-1:0]     positive_count_o,
  output logic [pgr_pkg::WEIGHT_W-1:0]      weight_now_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pgr_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pgr_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  pgr_pkg::cmd_t    cmd;
  pgr_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  pgr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pgr_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .status_o            (status),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .mode_i              (mode_i),
    .samples_tier0_i     (samples_tier0_i),
    .samples_tier1_i     (samples_tier1_i),
    .samples_tier2_i     (samples_tier2_i),
    .samples_tier3_i     (samples_tier3_i),
    .rank_index_i        (rank_index_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .entry_bin_o         (entry_bin_o),
    .entry_source_o      (entry_source_o),
    .entry_destination_o (entry_destination_o),
    .entry_valid_o       (entry_valid_o),
    .positive_count_o    (positive_count_o),
    .weight_now_o        (weight_now_o)
  );

endmodule
